// File: hdl/ray_box_slab_intersect_assert.svh
// Assertion macros used by the checker file of the slab intersection block.
`ifndef RAY_BOX_SLAB_INTERSECT_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, idle during reset.
`define RBSI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, idle during reset.
`define RBSI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/rbsi_pkg.sv
package rbsi_pkg;

	// Coordinate word and fraction width of the fixed-point format.
	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = 16;
	localparam int EPS_BITS   = 16;
	localparam int T_BITS     = COORD_BITS - 1;

	localparam logic [EPS_BITS-1:0] EPS_RESET = EPS_BITS'(1);

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t origin_x;
		coord_t origin_y;
		coord_t origin_z;
		coord_t dir_x;
		coord_t dir_y;
		coord_t dir_z;
		coord_t box_min_x;
		coord_t box_min_y;
		coord_t box_min_z;
		coord_t box_max_x;
		coord_t box_max_y;
		coord_t box_max_z;
	} in_t;

	typedef struct packed {
		logic              hit;
		logic [T_BITS-1:0] t_near;
		logic [T_BITS-1:0] t_far;
	} out_t;

	// What one axis lane hands to the merging stage.
	typedef struct packed {
		coord_t t_lo;
		coord_t t_hi;
		logic   par;
		logic   ins;
	} axis_res_t;

endpackage

// File: hdl/rbsi_lane.sv
module rbsi_lane #(
	parameter int FRAC = 16
) (
	input  logic                                    clk,
	input  logic [rbsi_pkg::EPS_BITS-1:0]           eps,
	input  rbsi_pkg::coord_t                        origin,
	input  rbsi_pkg::coord_t                        dir,
	input  rbsi_pkg::coord_t                        lo,
	input  rbsi_pkg::coord_t                        hi,
	input  logic [rbsi_pkg::COORD_BITS+FRAC+2:0]    adv,
	output rbsi_pkg::axis_res_t                     res
);
	import rbsi_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int QW = CB + 1 + FRAC;

	localparam logic [QW-1:0] CAP_POS = {{(QW-CB+1){1'b0}}, {(CB-1){1'b1}}};

	typedef struct packed {
		logic [QW-1:0] na;
		logic [QW-1:0] nb;
		logic [CB-1:0] ra;
		logic [CB-1:0] rb;
		logic [QW-1:0] qa;
		logic [QW-1:0] qb;
		logic [CB-1:0] b;
		logic          sa;
		logic          sb;
		logic          par;
		logic          ins;
	} dv_t;

	// One restoring division step on both quotients.
	function automatic dv_t dv_step(dv_t p);
		logic [CB:0] ta;
		logic [CB:0] tb;
		logic        ga;
		logic        gb;
		dv_t         nx;
		ta = {p.ra, p.na[QW-1]};
		tb = {p.rb, p.nb[QW-1]};
		ga = ta >= {1'b0, p.b};
		gb = tb >= {1'b0, p.b};
		nx = p;
		nx.na = {p.na[QW-2:0], 1'b0};
		nx.nb = {p.nb[QW-2:0], 1'b0};
		nx.ra = ga ? CB'(ta - {1'b0, p.b}) : ta[CB-1:0];
		nx.rb = gb ? CB'(tb - {1'b0, p.b}) : tb[CB-1:0];
		nx.qa = {p.qa[QW-2:0], ga};
		nx.qb = {p.qb[QW-2:0], gb};
		return nx;
	endfunction

	// Saturate a quotient magnitude and apply its sign.
	function automatic coord_t sat_sign(logic [QW-1:0] q, logic neg);
		logic [QW-1:0] cap;
		logic [QW-1:0] qs;
		cap = CAP_POS + QW'(neg);
		qs  = (q > cap) ? cap : q;
		return neg ? coord_t'(-qs[CB-1:0]) : coord_t'(qs[CB-1:0]);
	endfunction

	dv_t           dv_s [QW+1];
	dv_t           prep;
	logic signed [CB:0] dl;
	logic signed [CB:0] dh;
	logic [CB:0]   ml;
	logic [CB:0]   mh;
	logic [CB-1:0] dm;
	axis_res_t     cl_s;
	coord_t        t1;
	coord_t        t2;

	// Differences to the slab bounds, their magnitudes and the parallel test.
	always_comb begin
		dl = $signed({lo[CB-1], lo}) - $signed({origin[CB-1], origin});
		dh = $signed({hi[CB-1], hi}) - $signed({origin[CB-1], origin});
		ml = dl[CB] ? (CB+1)'(-dl) : dl;
		mh = dh[CB] ? (CB+1)'(-dh) : dh;
		dm = dir[CB-1] ? CB'(-dir) : dir;
		prep.na  = {ml, {FRAC{1'b0}}};
		prep.nb  = {mh, {FRAC{1'b0}}};
		prep.ra  = '0;
		prep.rb  = '0;
		prep.qa  = '0;
		prep.qb  = '0;
		prep.b   = dm;
		prep.sa  = dl[CB] ^ dir[CB-1];
		prep.sb  = dh[CB] ^ dir[CB-1];
		prep.par = dm <= CB'(eps);
		prep.ins = (origin >= lo) && (origin <= hi);
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			dv_s[0] <= prep;
		end
	end

	// One quotient bit per stage.
	for (genvar k = 1; k <= QW; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv[k]) begin
				dv_s[k] <= dv_step(dv_s[k-1]);
			end
		end
	end

	// Saturation and ordering of entry and exit.
	always_comb begin
		t1 = sat_sign(dv_s[QW].qa, dv_s[QW].sa);
		t2 = sat_sign(dv_s[QW].qb, dv_s[QW].sb);
	end

	always_ff @(posedge clk) begin
		if (adv[QW+1]) begin
			cl_s.t_lo <= (t1 > t2) ? t2 : t1;
			cl_s.t_hi <= (t1 > t2) ? t1 : t2;
			cl_s.par  <= dv_s[QW].par;
			cl_s.ins  <= dv_s[QW].ins;
		end
	end

	assign res = cl_s;

endmodule

// File: hdl/rbsi_merge.sv
module rbsi_merge (
	input  logic                clk,
	input  logic                adv,
	input  rbsi_pkg::axis_res_t ax [3],
	output rbsi_pkg::out_t      data
);
	import rbsi_pkg::*;

	localparam coord_t T_CAP = coord_t'({1'b0, {(COORD_BITS-1){1'b1}}});

	coord_t tmin;
	coord_t tmax;
	logic   ok;
	out_t   out_q;

	// Narrow the interval over the non-parallel axes; parallel ones must contain the origin.
	always_comb begin
		tmin = '0;
		tmax = T_CAP;
		ok   = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (ax[i].par) begin
				if (!ax[i].ins) begin
					ok = 1'b0;
				end
			end else begin
				if (ax[i].t_lo > tmin) begin
					tmin = ax[i].t_lo;
				end
				if (ax[i].t_hi < tmax) begin
					tmax = ax[i].t_hi;
				end
			end
		end
		if (tmin > tmax) begin
			ok = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.hit    <= ok;
			out_q.t_near <= ok ? tmin[T_BITS-1:0] : '0;
			out_q.t_far  <= ok ? tmax[T_BITS-1:0] : '0;
		end
	end

	assign data = out_q;

endmodule

// File: hdl/ray_box_slab_intersect.sv
// Ray against axis-aligned box by the slab method, signed fixed point (Q16.16 by default).
// One transfer is accepted per cycle unless an output stall has filled the pipeline back to
// its first stage, and every item gives exactly one result, computed by the three axis lanes whose
// dividers produce one quotient bit per stage. Stalls on the output stall only as
// far back as the pipeline is full, so empty stages keep taking transfers. The
// parallel threshold eps resets to 1 and is written by cfg_we with cfg_data.
module ray_box_slab_intersect #(
	parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rbsi_pkg::EPS_BITS-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  rbsi_pkg::in_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output rbsi_pkg::out_t                out_data
);
	import rbsi_pkg::*;

	localparam int QW = COORD_BITS + 1 + FRAC_BITS;
	localparam int NS = QW + 3;

	logic [EPS_BITS-1:0] eps_q;
	logic [NS-1:0]       v_q;
	logic [NS-1:0]       adv;
	axis_res_t           ax [3];

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_we) begin
			eps_q <= cfg_data;
		end
	end

	// A stage moves when it is empty or its successor moves.
	always_comb begin
		adv[NS-1] = !v_q[NS-1] || out_ready;
		for (int i = NS - 2; i >= 0; i--) begin
			adv[i] = !v_q[i] || adv[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (adv[0]) begin
				v_q[0] <= in_valid;
			end
			for (int i = 1; i < NS; i++) begin
				if (adv[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = v_q[NS-1];

	// Axis lanes.
	rbsi_lane #(.FRAC(FRAC_BITS)) u_lane_x (
		.clk(clk), .eps(eps_q), .origin(in_data.origin_x), .dir(in_data.dir_x),
		.lo(in_data.box_min_x), .hi(in_data.box_max_x), .adv(adv[NS-2:0]), .res(ax[0])
	);
	rbsi_lane #(.FRAC(FRAC_BITS)) u_lane_y (
		.clk(clk), .eps(eps_q), .origin(in_data.origin_y), .dir(in_data.dir_y),
		.lo(in_data.box_min_y), .hi(in_data.box_max_y), .adv(adv[NS-2:0]), .res(ax[1])
	);
	rbsi_lane #(.FRAC(FRAC_BITS)) u_lane_z (
		.clk(clk), .eps(eps_q), .origin(in_data.origin_z), .dir(in_data.dir_z),
		.lo(in_data.box_min_z), .hi(in_data.box_max_z), .adv(adv[NS-2:0]), .res(ax[2])
	);

	// Merging stage and output register.
	rbsi_merge u_merge (
		.clk(clk), .adv(adv[NS-1]), .ax(ax), .data(out_data)
	);

endmodule

// File: hdl/rbsi_checker.sv
`include "ray_box_slab_intersect_assert.svh"

module rbsi_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_ready,
	input rbsi_pkg::out_t out_data
);
	import rbsi_pkg::*;

	// A stalled result transfer keeps its payload.
	`RBSI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
	// A miss reports zero entry and exit parameters.
	`RBSI_ASSERT_NOW(a_miss_zero, out_valid && !out_data.hit, out_data.t_near == '0 && out_data.t_far == '0, "miss with non-zero parameters")
	// A hit reports an ordered interval.
	`RBSI_ASSERT_NOW(a_hit_order, out_valid && out_data.hit, out_data.t_near <= out_data.t_far, "hit with entry after exit")

endmodule

bind ray_box_slab_intersect rbsi_checker u_rbsi_checker (.*);
